// File: rtl/core/mlmc_pkg.sv
package mlmc_pkg;

    localparam int MAX_N_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 16;

    localparam int SIZE_W     = 5;
    localparam int SIZE_RESET = 10;
    localparam int COUNT_W    = 7;
    localparam int SUM_W      = 23;
    localparam int HITS_W     = 3;

    // Where the current element sits in the matrix
    typedef struct packed {
        logic has_up;
        logic has_left;
        logic last_col;
        logic last_row;
    } pos_flags_t;

    // Clamp a requested size into 2..max_n
    function automatic int clamp_size(input int size, input int max_n);
        int res;
        res = size;
        if (size < 2) begin
            res = 2;
        end
        else if (size > max_n) begin
            res = max_n;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/mlmc_line_buf.sv
module mlmc_line_buf #(
    parameter int WIDTH = mlmc_pkg::VALUE_WIDTH_DEF + 1,
    parameter int DEPTH = mlmc_pkg::MAX_N_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Forward the entry being written when both ports hit the same address
    always_ff @(posedge clk)
    begin
        if (re) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end
            else begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mlmc_judge.sv
module mlmc_judge #(
    parameter int VALUE_WIDTH = mlmc_pkg::VALUE_WIDTH_DEF
) (
    input  mlmc_pkg::pos_flags_t          pos,
    input  logic signed [VALUE_WIDTH-1:0] x_val,
    input  logic signed [VALUE_WIDTH-1:0] l_val,
    input  logic                          l_flag,
    input  logic signed [VALUE_WIDTH-1:0] p1_val,
    input  logic                          p1_flag,
    input  logic signed [VALUE_WIDTH-1:0] p2_val,
    input  logic                          p2_flag,
    output logic                          x_flag_new,
    output logic                          l_flag_new,
    output logic                          p2_flag_new,
    output logic [mlmc_pkg::HITS_W-1:0]   hits
);

    logic up;
    logic lf;
    logic ul;
    logic p1_flag_new;

    assign up = pos.has_up;
    assign lf = pos.has_left;
    assign ul = up && lf;

    // Clear a flag whenever a neighbor is not strictly larger. The meet of the
    // left element with the upper element at this column is deferred to here,
    // once that upper element has been fetched.
    always_comb
    begin
        x_flag_new  = !(lf && !(x_val < l_val)) && !(up && !(x_val < p2_val))
                      && !(ul && !(x_val < p1_val));
        l_flag_new  = l_flag && !(lf && !(l_val < x_val)) && !(ul && !(l_val < p2_val));
        p2_flag_new = p2_flag && !(up && !(p2_val < x_val)) && !(ul && !(p2_val < l_val));
        p1_flag_new = p1_flag && !(ul && !(p1_val < x_val));
    end

    // Count elements whose last neighbor just arrived
    always_comb
    begin
        hits = mlmc_pkg::HITS_W'(ul && p1_flag_new)
             + mlmc_pkg::HITS_W'(up && pos.last_col && p2_flag_new)
             + mlmc_pkg::HITS_W'(pos.last_row && lf && l_flag_new)
             + mlmc_pkg::HITS_W'(pos.last_row && pos.last_col && x_flag_new);
    end

endmodule

// File: rtl/core/matrix_local_minima_counter_core.sv
// The result beat is registered and presented in the cycle after the final element is accepted.
// Throughput: one element per cycle; a new element is taken while a result waits,
// except the final element of the next matrix, which holds until the result is taken.
// Per element: one line-buffer read (prefetched) plus four compares into the registers.
// Reset clears positions, running count and sum, the result valid, and sets size to 10.
// The line buffer is not cleared; every entry is written before its value is used.
module matrix_local_minima_counter_core #(
    parameter int MAX_N       = mlmc_pkg::MAX_N_DEF,
    parameter int VALUE_WIDTH = mlmc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mlmc_pkg::SIZE_W-1:0]         cfg_wdata,     // matrix_size
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // element_value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata   // minima_count, upper_sum
);

    localparam int IDX_W   = $clog2(MAX_N);
    localparam int ENTRY_W = VALUE_WIDTH + 1;
    localparam int COUNT_W = mlmc_pkg::COUNT_W;
    localparam int SUM_W   = mlmc_pkg::SUM_W;
    localparam int OUT_PAD = 32 - COUNT_W - SUM_W;
    localparam logic [IDX_W-1:0] NM1_RESET =
        IDX_W'(mlmc_pkg::clamp_size(mlmc_pkg::SIZE_RESET, MAX_N) - 1);

    logic [IDX_W-1:0] nm1_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;
    logic [COUNT_W-1:0] count_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic signed [VALUE_WIDTH-1:0] l_val_reg;
    logic                          l_flag_reg;
    logic signed [VALUE_WIDTH-1:0] p1_val_reg;
    logic                          p1_flag_reg;

    logic                    out_valid_reg;
    logic [COUNT_W-1:0]      out_count_reg;
    logic signed [SUM_W-1:0] out_sum_reg;

    logic [COUNT_W-1:0]      count_next;
    logic signed [SUM_W-1:0] sum_next;

    logic accept;
    logic is_last;
    logic [IDX_W-1:0] nm1_next;
    logic [IDX_W-1:0] col_next;
    logic [IDX_W-1:0] row_next;

    logic signed [VALUE_WIDTH-1:0] x_val;
    logic signed [VALUE_WIDTH-1:0] p2_val;
    logic                          p2_flag;
    logic [ENTRY_W-1:0]            rd_entry;

    mlmc_pkg::pos_flags_t pos;
    logic x_flag_new;
    logic l_flag_new;
    logic p2_flag_new;
    logic [mlmc_pkg::HITS_W-1:0] hits;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_entry;
    logic signed [SUM_W-1:0] x_ext;

    assign x_val = s_axis_tdata[VALUE_WIDTH-1:0];
    assign x_ext = SUM_W'(x_val);
    assign p2_val  = rd_entry[ENTRY_W-1:1];
    assign p2_flag = rd_entry[0];

    assign pos.has_up   = (row_reg != '0);
    assign pos.has_left = (col_reg != '0);
    assign pos.last_col = (col_reg == nm1_reg);
    assign pos.last_row = (row_reg == nm1_reg);

    assign is_last = pos.last_col && pos.last_row;
    // Hold the final element only while an earlier result is still stalled
    assign s_axis_tready = !(out_valid_reg && !m_axis_tready && is_last);
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (cfg_wdata < mlmc_pkg::SIZE_W'(2)) begin
            nm1_next = IDX_W'(1);
        end
        else if (int'(cfg_wdata) > MAX_N) begin
            nm1_next = IDX_W'(MAX_N - 1);
        end
        else begin
            nm1_next = IDX_W'(cfg_wdata - mlmc_pkg::SIZE_W'(1));
        end
    end

    always_comb
    begin
        col_next = pos.last_col ? '0 : col_reg + IDX_W'(1);
        row_next = row_reg;
        if (pos.last_col) begin
            row_next = pos.last_row ? '0 : row_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg + COUNT_W'(hits);
        sum_next   = sum_reg;
        if (col_reg > row_reg) begin
            sum_next = sum_reg + x_ext;
        end
    end

    // Retire the finished left element; at a row start, retire the previous row's tail
    always_comb
    begin
        wr_en    = accept && (pos.has_left || pos.has_up);
        wr_addr  = pos.has_left ? col_reg - IDX_W'(1) : nm1_reg;
        wr_entry = pos.has_left ? {l_val_reg, l_flag_new} : {l_val_reg, l_flag_reg};
    end

    mlmc_line_buf #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_N),
        .AW    (IDX_W)
    ) u_line_buf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (col_next),
        .rdata (rd_entry)
    );

    mlmc_judge #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_judge (
        .pos         (pos),
        .x_val       (x_val),
        .l_val       (l_val_reg),
        .l_flag      (l_flag_reg),
        .p1_val      (p1_val_reg),
        .p1_flag     (p1_flag_reg),
        .p2_val      (p2_val),
        .p2_flag     (p2_flag),
        .x_flag_new  (x_flag_new),
        .l_flag_new  (l_flag_new),
        .p2_flag_new (p2_flag_new),
        .hits        (hits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            nm1_reg   <= NM1_RESET;
            row_reg   <= '0;
            col_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (cfg_we) begin
            nm1_reg   <= nm1_next;
            row_reg   <= '0;
            col_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (is_last) begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
        end
    end

    // Slide the neighbor window
    always_ff @(posedge clk)
    begin
        if (accept) begin
            l_val_reg   <= x_val;
            l_flag_reg  <= x_flag_new;
            p1_val_reg  <= p2_val;
            p1_flag_reg <= p2_flag_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && is_last) begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_last) begin
            out_count_reg <= count_next;
            out_sum_reg   <= sum_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_sum_reg, out_count_reg};

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int GRID_MAX    = 16;
    localparam int ITEM_TARGET = 1800;

    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_MAX,
        FILL_MIN,
        FILL_GRID
    } fill_kind_t;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    typedef struct {
        logic [mlmc_pkg::COUNT_W-1:0]      minima;
        logic signed [mlmc_pkg::SUM_W-1:0] upper_sum;
    } tally_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // element_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // minima_count, upper_sum

    matrix_local_minima_counter_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Predictor state
    logic [4:0]                        size_reg;
    logic signed [15:0]                line_val [0:2*GRID_MAX-1];
    bit                                line_cand [0:2*GRID_MAX-1];
    int                                pos_row;
    int                                pos_col;
    logic [mlmc_pkg::COUNT_W-1:0]      run_minima;
    logic signed [mlmc_pkg::SUM_W-1:0] run_sum;
    tally_t                            pending_tallies [$];

    int       mismatches = 0;
    int       cycles = 0;
    int       items_sent = 0;
    int       burst_left = 0;
    bit       gaps_on = 1'b0;
    int       hold_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_phase = 0;

    function automatic int grid_size();
        int n;
        n = size_reg;
        if (n < 2) n = 2;
        if (n > GRID_MAX) n = GRID_MAX;
        return n;
    endfunction

    function automatic void clear_scan();
        pos_row    = 0;
        pos_col    = 0;
        run_minima = '0;
        run_sum    = '0;
    endfunction

    // Earlier neighbor a against the newly arrived element b
    function automatic void pair_compare(int a, int b);
        if (!(line_val[a] < line_val[b])) line_cand[a] = 1'b0;
        if (!(line_val[b] < line_val[a])) line_cand[b] = 1'b0;
    endfunction

    function automatic void settle(int slot);
        if (line_cand[slot]) run_minima = run_minima + 1'b1;
    endfunction

    function automatic void absorb_element(logic signed [15:0] v);
        int n, r, c, cur, prv;
        tally_t t;
        n = grid_size();
        r = pos_row;
        c = pos_col;
        if (r >= n || c >= n) begin
            r = 0;
            c = 0;
        end
        cur = (r % 2) * GRID_MAX;
        prv = ((r + 1) % 2) * GRID_MAX;
        line_val[cur + c]  = v;
        line_cand[cur + c] = 1'b1;
        if (c > 0) pair_compare(cur + c - 1, cur + c);
        if (r > 0) begin
            pair_compare(prv + c, cur + c);
            if (c > 0) pair_compare(prv + c - 1, cur + c);
            if (c + 1 < n) pair_compare(prv + c + 1, cur + c);
        end
        if (c > r) run_sum = run_sum + {{(mlmc_pkg::SUM_W-16){v[15]}}, v};
        // decide elements whose last neighbor just arrived
        if (r > 0) begin
            if (c > 0) settle(prv + c - 1);
            if (c == n - 1) settle(prv + c);
        end
        if (r == n - 1) begin
            if (c > 0) settle(cur + c - 1);
            if (c == n - 1) settle(cur + c);
        end
        c++;
        if (c == n) begin
            c = 0;
            r++;
        end
        if (r == n) begin
            t.minima    = run_minima;
            t.upper_sum = run_sum;
            pending_tallies.push_back(t);
            clear_scan();
        end
        else begin
            pos_row = r;
            pos_col = c;
        end
    endfunction

    function automatic logic [15:0] pick_value(fill_kind_t kind, int r, int c);
        logic [15:0] v;
        case (kind)
            FILL_NARROW:  v = 16'($signed($urandom_range(0, 6)) - 3);
            FILL_EXTREME:
                case ($urandom_range(0, 3))
                    0:       v = 16'h8000;
                    1:       v = 16'h7fff;
                    2:       v = 16'h8001;
                    default: v = 16'h0000;
                endcase
            FILL_MAX:     v = 16'h7fff;
            FILL_MIN:     v = 16'h8000;
            FILL_GRID:    v = (r % 2 == 0 && c % 2 == 0) ? -16'sd100 : 16'sd100;
            default:      v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_element(logic [15:0] v);
        if (gaps_on && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
        absorb_element(v);
        items_sent++;
    endtask

    // Send the first count elements of a matrix in raster order
    task automatic send_matrix(fill_kind_t kind, int count);
        int n;
        n = grid_size();
        for (int k = 0; k < count; k++) send_element(pick_value(kind, k / n, k % n));
    endtask

    task automatic write_size(logic [4:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_tallies.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_reg = v;
        clear_scan();
    endtask

    task automatic test_corner_extremes();
        // size 0 runs as 2: opposite corners tie diagonally, so no minimum
        write_size(5'd0);
        send_element(16'h8000);
        send_element(16'h7fff);
        send_element(16'h7fff);
        send_element(16'h8000);
        // size 1 runs as 2: all ties, nothing strict
        write_size(5'd1);
        repeat (4) send_element(16'h0005);
        write_size(5'd2);
        send_element(16'h7fff);
        send_element(16'h8000);
        send_element(16'h8000);
        send_element(16'h7fff);
    endtask

    task automatic test_drop_partial();
        write_size(5'd3);
        send_matrix(FILL_NARROW, 5);
        // drop the partial matrix and start over
        write_size(5'd3);
        send_matrix(FILL_EXTREME, 9);
    endtask

    task automatic test_size_limits();
        write_size(5'd16);
        send_matrix(FILL_MAX, 256);
        write_size(5'd31);
        send_matrix(FILL_MIN, 256);
        write_size(5'd17);
        send_matrix(FILL_GRID, 256);
    endtask

    task automatic test_backpressure();
        write_size(5'd2);
        gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        hold_left = 300;
        for (int m = 0; m < 6; m++) send_matrix(FILL_RANDOM, 4);
    endtask

    task automatic test_random_matrices();
        int n;
        int elems;
        while (items_sent < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 2) != 0);
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_size(5'($urandom_range(17, 31)));
                    1:       write_size(5'($urandom_range(0, 1)));
                    2:       write_size(5'($urandom_range(7, 16)));
                    default: write_size(5'($urandom_range(2, 6)));
                endcase
            end
            n = grid_size();
            elems = n * n;
            // now and then break the matrix off early
            if ($urandom_range(0, 9) == 0) elems = $urandom_range(1, elems - 1);
            send_matrix(fill_kind_t'($urandom_range(0, 2)), elems);
            if (elems < n * n) write_size(size_reg);
        end
    endtask

    always @(posedge clk) begin
        rx_phase = rx_phase + 1;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_mode == RX_ALWAYS) m_axis_tready <= 1'b1;
        else if (rx_mode == RX_RANDOM) m_axis_tready <= ($urandom_range(0, 2) != 0);
        else m_axis_tready <= ((rx_phase % 11) < 4);
    end

    always @(posedge clk) begin
        tally_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_tallies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: %h", m_axis_tdata);
            end
            else begin
                want = pending_tallies.pop_front();
                if (m_axis_tdata[6:0] !== want.minima
                    || m_axis_tdata[29:7] !== want.upper_sum
                    || m_axis_tdata[31:30] !== 2'b00) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: count exp %0d got %0d, ",
                                  "sum exp %0d got %0d, pad %b"},
                                 want.minima, m_axis_tdata[6:0], want.upper_sum,
                                 $signed(m_axis_tdata[29:7]), m_axis_tdata[31:30]);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[matrix_local_minima_counter_core] ERROR");
            $finish;
        end
    end

    initial begin
        size_reg = 5'd10;
        clear_scan();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_extremes();
        test_drop_partial();
        test_backpressure();
        test_size_limits();
        test_random_matrices();

        s_axis_tvalid <= 1'b0;
        rx_mode = RX_RANDOM;
        while (pending_tallies.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_tallies.size() == 0)
            $display("[matrix_local_minima_counter_core] OK");
        else
            $display("[matrix_local_minima_counter_core] ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mlmc_pkg.sv
rtl/core/mlmc_line_buf.sv
rtl/core/mlmc_judge.sv
rtl/core/matrix_local_minima_counter_core.sv
sim/tb.sv
